>>> hw/rtl/postfix_stack_evaluator_core_defines.svh
// Assertion macros shared by the postfix evaluator RTL.
`ifndef POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define PSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pse assertion failed");
// Next-cycle implication, checked outside reset.
`define PSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pse assertion failed");
`else
`define PSE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/pse_pkg.sv
// Package: widths, token and status codes, divider request and response types.
`default_nettype none
package pse_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int NUM_W       = 31;
    localparam int OP_W        = 3;
    localparam int ST_W        = 3;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ITER_W      = $clog2(DATA_W);

    typedef enum logic [OP_W-1:0] {
        OP_NUM = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_MOD = 3'd5,
        OP_INV = 3'd6,
        OP_END = 3'd7
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FEW      = 3'd1,
        ST_INVALID  = 3'd2,
        ST_DIVZERO  = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_LEFTOVER = 3'd5
    } status_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rem;
    } div_res_t;
endpackage
`default_nettype wire

>>> hw/rtl/pse_stream_if.sv
// Interfaces: token input channel and result output channel.
`default_nettype none
interface pse_tok_if
    import pse_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [NUM_W-1:0] number;

    modport source (output valid, output op, output number, input ready);
    modport sink   (input valid, input op, input number, output ready);
endinterface

interface pse_res_if
    import pse_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/pse_stack_ram.sv
// Generic single-write, single-read synchronous RAM for the operand stack.
`default_nettype none
module pse_stack_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

>>> hw/rtl/pse_divider.sv
// Iterative signed restoring divider, one quotient bit per cycle.
`default_nettype none
`include "postfix_stack_evaluator_core_defines.svh"
module pse_divider
    import pse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t rsp
);
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic              qneg_reg, qneg_next;
    logic              rneg_reg, rneg_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};

        if (req.start)
        begin
            // take magnitudes; the most negative value maps onto itself unsigned
            busy_next = 1'b1;
            iter_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend[DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
            dsr_next  = req.divisor[DATA_W-1] ? (~req.divisor + 1'b1) : req.divisor;
            qneg_next = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
            rneg_next = req.dividend[DATA_W-1];
        end
        else if (busy_reg)
        begin
            // keep the trial difference only when it does not borrow
            rem_next  = diff[DATA_W+1] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
            quo_next  = {quo_reg[DATA_W-2:0], ~diff[DATA_W+1]};
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
            qneg_reg <= 1'b0;
            rneg_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dsr_reg  <= dsr_next;
            qneg_reg <= qneg_next;
            rneg_reg <= rneg_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign rsp.rem  = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;

    `PSE_ASSERT_NOW(a_div_no_restart, clk, rst_n, req.start, !busy_reg)
    `PSE_ASSERT_NOW(a_div_nonzero, clk, rst_n, req.start, req.divisor != '0)
    `PSE_ASSERT_NOW(a_div_done_idle, clk, rst_n, done_reg, !busy_reg && !req.start)
endmodule
`default_nettype wire

>>> hw/rtl/postfix_stack_evaluator_core.sv
// Top level: postfix token sequencer around the operand stack RAM and the divider.
// Steps per token beat: number, invalid, end and any token after an error finish in the idle state;
// add, sub and mul also pass through a load state (stack RAM read, then execute into the top register).
// div and mod pass through the load state, then wait for the 32-step divider before writeback.
// End result appears in the output register the cycle after the end beat is accepted.
// Reset (rst_n low, async) empties the stack, clears the error and drops the result.
`default_nettype none
`include "postfix_stack_evaluator_core_defines.svh"
module postfix_stack_evaluator_core
    import pse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pse_tok_if.sink   tok,
    pse_res_if.source res
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    status_t           err_reg, err_next;
    // top of stack lives in a register; the RAM holds the entries below it
    logic [DATA_W-1:0] tos_reg, tos_next;
    op_t               op_reg, op_next;
    logic              res_valid_reg, res_valid_next;
    status_t           res_status_reg, res_status_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;

    logic                tok_acc;
    op_t                 tok_op;
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic [2*DATA_W-1:0] prod;
    div_req_t            div_req;
    div_res_t            div_res;

    assign tok_op  = op_t'(tok.op);
    // only an end beat needs the result register free; everything else flows on
    assign tok.ready = (state_reg == S_IDLE)
                     && (!res_valid_reg || res.ready || tok_op != OP_END);
    assign tok_acc = tok.valid && tok.ready;

    // a push spills the old top into the RAM; an operator fetches the entry below it
    assign ram_waddr = ADDR_W'(count_reg - CNT_W'(1));
    assign ram_raddr = ADDR_W'(count_reg - CNT_W'(2));
    assign prod      = ram_rdata * tos_reg;

    pse_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tos_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pse_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        tos_next        = tos_reg;
        op_next         = op_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = ram_rdata;
        div_req.divisor  = tos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (tok_acc)
                begin
                    op_next = tok_op;
                    if (tok_op == OP_END)
                    begin
                        // report the first error, else check for exactly one value
                        res_valid_next = 1'b1;
                        res_value_next = '0;
                        if (err_reg != ST_OK)
                        begin
                            res_status_next = err_reg;
                        end
                        else if (count_reg != CNT_W'(1))
                        begin
                            res_status_next = ST_LEFTOVER;
                        end
                        else
                        begin
                            res_status_next = ST_OK;
                            res_value_next  = tos_reg;
                        end
                        count_next = '0;
                        err_next   = ST_OK;
                    end
                    else if (err_reg == ST_OK)
                    begin
                        case (tok_op)
                            OP_NUM:
                            begin
                                if (count_reg >= CNT_W'(STACK_DEPTH))
                                begin
                                    err_next = ST_OVERFLOW;
                                end
                                else
                                begin
                                    ram_we     = (count_reg != '0);
                                    tos_next   = {1'b0, tok.number};
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            OP_INV:
                            begin
                                err_next = ST_INVALID;
                            end
                            OP_ADD, OP_SUB, OP_MUL:
                            begin
                                if (count_reg < CNT_W'(2))
                                begin
                                    err_next = ST_FEW;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    state_next = S_LOAD;
                                end
                            end
                            OP_DIV, OP_MOD:
                            begin
                                // the right operand is the top register: test it up front
                                if (count_reg < CNT_W'(2))
                                begin
                                    err_next = ST_FEW;
                                end
                                else if (tos_reg == '0)
                                begin
                                    err_next = ST_DIVZERO;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    state_next = S_LOAD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_LOAD:
            begin
                // left operand arrives from the RAM this cycle
                state_next = S_IDLE;
                case (op_reg)
                    OP_ADD:
                    begin
                        tos_next   = ram_rdata + tos_reg;
                        count_next = count_reg - CNT_W'(1);
                    end
                    OP_SUB:
                    begin
                        tos_next   = ram_rdata - tos_reg;
                        count_next = count_reg - CNT_W'(1);
                    end
                    OP_MUL:
                    begin
                        tos_next   = prod[DATA_W-1:0];
                        count_next = count_reg - CNT_W'(1);
                    end
                    OP_DIV, OP_MOD:
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DIV:
            begin
                // hold until the divider finishes, then collapse two entries into one
                if (div_res.done)
                begin
                    tos_next   = (op_reg == OP_MOD) ? div_res.rem : div_res.quo;
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            err_reg        <= ST_OK;
            tos_reg        <= '0;
            op_reg         <= OP_NUM;
            res_valid_reg  <= 1'b0;
            res_status_reg <= ST_OK;
            res_value_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            err_reg        <= err_next;
            tos_reg        <= tos_next;
            op_reg         <= op_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
        end
    end

    assign res.valid  = res_valid_reg;
    assign res.status = res_status_reg;
    assign res.value  = $signed(res_value_reg);

    `PSE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(STACK_DEPTH))
    `PSE_ASSERT_NOW(a_busy_operands, clk, rst_n, state_reg != S_IDLE, count_reg >= CNT_W'(2))
    `PSE_ASSERT_NEXT(a_end_clears, clk, rst_n, tok_acc && tok_op == OP_END, count_reg == '0 && err_reg == ST_OK && res_valid_reg)
    `PSE_ASSERT_NEXT(a_error_freezes, clk, rst_n, err_reg != ST_OK && !(tok_acc && tok_op == OP_END), $stable(count_reg) && $stable(err_reg))
endmodule
`default_nettype wire
